>>> rtl/owa_pkg.sv
`default_nettype none
package owa_pkg;

   localparam int SAMPLE_W     = 10;
   localparam int PERIOD_W     = 16;
   localparam int RAW_W        = 16;
   // dividend wide enough for the kept sum of a full window
   localparam int DIV_W        = 15;
   localparam int DIVS_W       = 10;
   localparam int DIV_CNT_W    = 5;
   localparam int THR_W        = 14;
   localparam int PROD_W       = 26;
   localparam int RSP_DATA_W   = 32;

   // x / 1023 as (x * ceil(2^36 / 1023)) >> 36, exact for x below 2^26
   localparam int PULSE_SHIFT   = 36;
   localparam int PULSE_RECIP_W = 27;
   localparam int PULSE_PROD_W  = PROD_W + PULSE_RECIP_W;

   localparam logic [RAW_W-1:0]         SAMPLE_MAX   = 16'd1023;
   localparam logic [PERIOD_W-1:0]      PERIOD_RESET = 16'd1000;
   localparam logic [PULSE_RECIP_W-1:0] PULSE_RECIP  = 27'd67174465;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

>>> rtl/owa_cell.sv
`default_nettype none
module owa_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  shift_en,
   input  owa_pkg::sample_type  sample_in,
   output owa_pkg::sample_type  sample_out
);

   owa_pkg::sample_type sample_ff;
   owa_pkg::sample_type sample_in_q;

   assign sample_in_q = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_q;
      end
   end

   assign sample_out = sample_ff;

endmodule
`default_nettype wire

>>> rtl/owa_div.sv
`default_nettype none
module owa_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [owa_pkg::DIV_W-1:0]        dividend,
   input  wire  [owa_pkg::DIVS_W-1:0]       divisor,
   output logic [owa_pkg::DIV_W-1:0]        quotient,
   output owa_pkg::div_stat_type            status
);

   logic [owa_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          done_ff;
   logic [owa_pkg::DIV_W-1:0]     quot_ff;
   logic [owa_pkg::DIVS_W-1:0]    rem_ff;
   logic [owa_pkg::DIVS_W-1:0]    rem_in;
   logic [owa_pkg::DIVS_W:0]      shifted;
   logic [owa_pkg::DIVS_W:0]      trial;
   logic                          qbit;

   // restoring step, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[owa_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, divisor};
      qbit    = ~trial[owa_pkg::DIVS_W];
      rem_in  = qbit ? trial[owa_pkg::DIVS_W-1:0] : shifted[owa_pkg::DIVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= owa_pkg::DIV_CNT_W'(owa_pkg::DIV_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == owa_pkg::DIV_CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         quot_ff <= {quot_ff[owa_pkg::DIV_W-2:0], qbit};
         rem_ff  <= rem_in;
      end
   end

   assign quotient    = quot_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

>>> rtl/outlier_rejecting_window_average_top.sv
// Outlier-rejecting window average.
// Request channel (req_*): one converter reading per request, raw_sample in
// tdata and read_ok in tuser. A failed read or a reading above 1023 repeats
// the last good reading. The value is pushed into a ring of WINDOW_LEN cells.
// Response channel (rsp_*): one response per request carrying the average of
// the samples within ten percent of the window mean and the PWM pulse width
// period * average / 1023.
// Configuration: csr_wen writes csr_wdata into the PWM period register;
// write only while the block is idle.
// One request is worked at a time; req_tready is high only when idle.
// From acceptance to rsp_tvalid the block makes two walks round the cell ring,
// a bit-serial divide for the kept average and six further steps; the divide
// is skipped when the kept sum is zero. req_tready returns high in the same
// cycle as rsp_tvalid is raised for the response.
// The response sits in an output register; if the receiver stalls, the next
// request may be accepted and worked, and its response waits until the
// register is free.
// Reset clears the window, the last good sample and all handshakes, and sets
// the period to 1000 us.
`default_nettype none
module outlier_rejecting_window_average_top #(
   parameter int WINDOW_LEN = 10
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: [15:0] raw_sample
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   // req_tuser: [0] read_ok
   input  wire         req_tuser,
   // rsp_tdata: [9:0] filtered_average, [25:10] pulse_width_us, [31:26] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,
   input  wire         csr_wen,
   input  wire  [15:0] csr_wdata
);

   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = $clog2(WINDOW_LEN * 1023 + 1);
   // sum / WINDOW_LEN as a reciprocal multiply, exact over the whole sum range
   localparam int MEAN_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
   localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int MEAN_PROD_W = SUM_W + MEAN_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_THRESH,
      ST_KEEP,
      ST_AVG,
      ST_AVG_DIV,
      ST_MUL,
      ST_PULSE,
      ST_OUT
   } state_type;

   state_type                          state_ff;
   logic [CNT_W-1:0]                   cnt_ff;
   logic [SUM_W-1:0]                   sum_ff;
   logic [SUM_W-1:0]                   kept_sum_ff;
   logic [CNT_W-1:0]                   kept_cnt_ff;
   owa_pkg::sample_type                mean_ff;
   owa_pkg::sample_type                avg_ff;
   owa_pkg::sample_type                last_good_ff;
   logic [owa_pkg::THR_W-1:0]          thr_lo_ff;
   logic [owa_pkg::THR_W-1:0]          thr_hi_ff;
   logic [owa_pkg::PROD_W-1:0]         prod_ff;
   logic [owa_pkg::PERIOD_W-1:0]       period_ff;
   logic                               div_start_ff;
   logic                               rsp_tvalid_ff;
   logic [owa_pkg::RSP_DATA_W-1:0]     rsp_tdata_ff;

   logic                               accept;
   logic                               sample_good;
   owa_pkg::sample_type                new_sample;
   owa_pkg::sample_type                tail;
   logic [owa_pkg::THR_W-1:0]          tail_x10;
   logic                               rotate;
   logic [MEAN_PROD_W-1:0]             mean_prod;
   logic [owa_pkg::PULSE_PROD_W-1:0]   pulse_prod;
   logic [owa_pkg::DIV_W-1:0]          div_dividend;
   logic [owa_pkg::DIVS_W-1:0]         div_divisor;
   logic [owa_pkg::DIV_W-1:0]          div_quot;
   owa_pkg::div_stat_type              div_stat;
   owa_pkg::sample_type                cell_q [WINDOW_LEN];
   owa_pkg::sample_type                cell_in [WINDOW_LEN];

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid & req_tready;
   assign sample_good = req_tuser && (req_tdata <= owa_pkg::SAMPLE_MAX);
   assign new_sample  = sample_good ? req_tdata[owa_pkg::SAMPLE_W-1:0] : last_good_ff;
   assign rotate      = (state_ff == ST_SUM) || (state_ff == ST_KEEP);
   assign tail        = cell_q[WINDOW_LEN-1];
   assign tail_x10    = owa_pkg::THR_W'(tail) * owa_pkg::THR_W'(10);

   assign mean_prod  = MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(MEAN_RECIP);
   assign pulse_prod = owa_pkg::PULSE_PROD_W'(prod_ff) *
                       owa_pkg::PULSE_PROD_W'(owa_pkg::PULSE_RECIP);

   // cell 0 takes the new sample on a request, otherwise the ring wraps round
   assign cell_in[0] = accept ? new_sample : tail;

   genvar g;
   generate
      for (g = 0; g < WINDOW_LEN; g++) begin : g_cell
         if (g > 0) begin : g_link
            assign cell_in[g] = cell_q[g-1];
         end
         owa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (accept | rotate),
            .sample_in  (cell_in[g]),
            .sample_out (cell_q[g])
         );
      end
   endgenerate

   assign div_dividend = owa_pkg::DIV_W'(kept_sum_ff);
   assign div_divisor  = owa_pkg::DIVS_W'(kept_cnt_ff);

   owa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         last_good_ff  <= '0;
         period_ff     <= owa_pkg::PERIOD_RESET;
         div_start_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_wen) begin
            period_ff <= csr_wdata;
         end
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (sample_good) begin
                     last_good_ff <= req_tdata[owa_pkg::SAMPLE_W-1:0];
                  end
                  cnt_ff   <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               sum_ff <= sum_ff + SUM_W'(tail);
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(WINDOW_LEN - 1)) begin
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               mean_ff  <= mean_prod[MEAN_SHIFT +: owa_pkg::SAMPLE_W];
               state_ff <= ST_THRESH;
            end
            ST_THRESH: begin
               thr_lo_ff   <= owa_pkg::THR_W'(mean_ff) * owa_pkg::THR_W'(9);
               thr_hi_ff   <= owa_pkg::THR_W'(mean_ff) * owa_pkg::THR_W'(11);
               cnt_ff      <= '0;
               kept_sum_ff <= '0;
               kept_cnt_ff <= '0;
               state_ff    <= ST_KEEP;
            end
            ST_KEEP: begin
               if (!(tail_x10 < thr_lo_ff || tail_x10 > thr_hi_ff)) begin
                  kept_sum_ff <= kept_sum_ff + SUM_W'(tail);
                  kept_cnt_ff <= kept_cnt_ff + 1'b1;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(WINDOW_LEN - 1)) begin
                  state_ff <= ST_AVG;
               end
            end
            ST_AVG: begin
               // an empty or all-zero kept set gives zero
               if (kept_sum_ff == '0) begin
                  avg_ff   <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_AVG_DIV;
               end
            end
            ST_AVG_DIV: begin
               if (div_stat.done) begin
                  avg_ff   <= div_quot[owa_pkg::SAMPLE_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= owa_pkg::PROD_W'(period_ff) * owa_pkg::PROD_W'(avg_ff);
               state_ff <= ST_PULSE;
            end
            ST_PULSE: begin
               rsp_tdata_ff[owa_pkg::SAMPLE_W-1:0] <= avg_ff;
               rsp_tdata_ff[owa_pkg::RSP_DATA_W-1:owa_pkg::SAMPLE_W] <=
                  (owa_pkg::RSP_DATA_W - owa_pkg::SAMPLE_W)'(
                     pulse_prod[owa_pkg::PULSE_SHIFT +: owa_pkg::PERIOD_W]);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata     <= rsp_tdata_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule
`default_nettype wire
